[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pidq_pkg.sv]
// ----------------------------------------------------------------------------
// pidq_pkg
// Codes and shared types for the pending id queue.
// ----------------------------------------------------------------------------
package pidq_pkg;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_DROP     = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST  = 32'd10;
    localparam logic [CAP_W-1:0]      CAPACITY_RST = 5'd16;

    // per-cell controls, decoded from the sequencer
    typedef struct packed {
        logic shift;      // take the right neighbor's entry
        logic load_head;  // take the head entry (rotate to the tail)
        logic load_new;   // take the incoming entry
    } cell_ctl_t;

endpackage

[sv/pidq_cell.sv]
// ----------------------------------------------------------------------------
// pidq_cell
// One queue slot: holds an id and its time stamp, moves data to its left
// neighbor on a shift and takes the head entry or a new entry on request.
// ----------------------------------------------------------------------------
module pidq_cell #(
    parameter int ID_WIDTH   = 32,
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  pidq_pkg::cell_ctl_t   ctl,
    input  logic [ID_WIDTH-1:0]   right_id,
    input  logic [TIME_WIDTH-1:0] right_stamp,
    input  logic [ID_WIDTH-1:0]   head_id,
    input  logic [TIME_WIDTH-1:0] head_stamp,
    input  logic [ID_WIDTH-1:0]   new_id,
    input  logic [TIME_WIDTH-1:0] new_stamp,
    output logic [ID_WIDTH-1:0]   id,
    output logic [TIME_WIDTH-1:0] stamp
);
    import pidq_pkg::*;

    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [TIME_WIDTH-1:0] stamp_reg, stamp_next;

    always_comb
    begin
        id_next    = id_reg;
        stamp_next = stamp_reg;
        if (ctl.load_new)
        begin
            id_next    = new_id;
            stamp_next = new_stamp;
        end
        else if (ctl.shift)
        begin
            id_next    = right_id;
            stamp_next = right_stamp;
        end
        else if (ctl.load_head)
        begin
            id_next    = head_id;
            stamp_next = head_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        stamp_reg <= stamp_next;
    end

    assign id    = id_reg;
    assign stamp = stamp_reg;

endmodule

[sv/pending_id_queue_with_timeout_core.sv]
// Operation: an add first evicts the oldest entries, one per queue step, then
//   appends; a search walks the queued entries through the head, one queue step
//   per cycle while the output can take any drop verdict. One item at a time:
//   a new item is accepted only when the previous one has finished.
// Reset: rst_n clears the queue count, the sequencer and the output valid;
//   timeout returns to 10 and capacity to 16. Cell contents are not cleared.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pending_id_queue_with_timeout_core
// Age-ordered queue of pending ids in a chain of cells. Adds append at the
// tail; searches rotate the queue through the head, dropping expired entries.
// ----------------------------------------------------------------------------
module pending_id_queue_with_timeout_core #(
    parameter int DEPTH      = 16,
    parameter int ID_WIDTH   = 32,
    parameter int TIME_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidq_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [ID_WIDTH-1:0]               pkt_id,
    input  logic [TIME_WIDTH-1:0]             now,
    // results
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [ID_WIDTH-1:0]               result_id,
    output logic                              last
);
    import pidq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH);
    localparam int CW    = ((CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W) + 1;
    localparam int CMP_W = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_SRCH} state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    logic                    found_reg, found_next;
    logic [ID_WIDTH-1:0]     id_reg, id_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    logic [CFG_DATA_W-1:0]   timeout_reg, timeout_next;
    logic [CAP_W-1:0]        capacity_reg, capacity_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [ID_WIDTH-1:0]     result_id_reg, result_id_next;
    logic                    last_reg, last_next;

    logic [ID_WIDTH-1:0]     cell_id    [DEPTH];
    logic [TIME_WIDTH-1:0]   cell_stamp [DEPTH];
    cell_ctl_t               cell_ctl   [DEPTH];

    logic [TIME_WIDTH-1:0]   age;
    logic                    age_gt;
    logic                    match;
    logic                    expire;
    logic                    keep;
    logic [CW-1:0]           cap_ext;
    logic [CW-1:0]           eff_cap;
    logic                    need_drop;
    logic                    out_free;
    logic                    step;
    logic                    keep_sel;
    logic                    write;
    logic [CNT_W-1:0]        top;

    // head of the queue is always cell 0
    assign age    = now_reg - cell_stamp[0];
    assign age_gt = CMP_W'(age) > CMP_W'(timeout_reg);
    assign match  = !found_reg && (cell_id[0] == id_reg);
    assign expire = !found_reg && !match && age_gt;
    assign keep   = !match && !expire;

    assign cap_ext = CW'(capacity_reg);
    always_comb
    begin
        eff_cap = cap_ext;
        if (cap_ext < CW'(2))
            eff_cap = CW'(2);
        else if (cap_ext > CW'(DEPTH))
            eff_cap = CW'(DEPTH);
    end

    // evict while the queue is not empty and count >= effective capacity - 1
    assign need_drop = (CW'(count_reg) >= eff_cap - CW'(1)) && (count_reg != '0);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        timeout_next   = timeout_reg;
        capacity_next  = capacity_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        result_id_next = result_id_reg;
        last_next      = last_reg;
        step           = 1'b0;
        keep_sel       = 1'b0;
        write          = 1'b0;
        top            = count_reg - CNT_W'(1);

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIMEOUT:  timeout_next  = cfg_data;
                REG_CAPACITY: capacity_next = cfg_data[CAP_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next    = pkt_id;
                    now_next   = now;
                    rem_next   = count_reg;
                    kept_next  = '0;
                    found_next = 1'b0;
                    state_next = (kind == KIND_ADD) ? S_ADD : S_SRCH;
                end
            end
            S_ADD:
            begin
                if (need_drop)
                begin
                    // shift everything toward the head, oldest falls off
                    step       = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else if (out_free)
                begin
                    write          = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    out_valid_next = 1'b1;
                    status_next    = ST_ADDED;
                    result_id_next = id_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SRCH:
            begin
                top = rem_reg + kept_reg - CNT_W'(1);
                if (rem_reg != '0)
                begin
                    if (!expire || out_free)
                    begin
                        step       = 1'b1;
                        keep_sel   = keep;
                        rem_next   = rem_reg - CNT_W'(1);
                        kept_next  = kept_reg + CNT_W'(keep);
                        found_next = found_reg || match;
                        if (expire)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_DROP;
                            result_id_next = cell_id[0];
                            last_next      = 1'b0;
                        end
                    end
                end
                else if (out_free)
                begin
                    count_next     = kept_reg;
                    out_valid_next = 1'b1;
                    status_next    = found_reg ? ST_FOUND : ST_NOTFOUND;
                    result_id_next = id_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            timeout_reg   <= TIMEOUT_RST;
            capacity_reg  <= CAPACITY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            timeout_reg   <= timeout_next;
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        now_reg       <= now_next;
        status_reg    <= status_next;
        result_id_reg <= result_id_next;
        last_reg      <= last_next;
    end

    // cell chain; cells below top shift, top takes the rotated head entry
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        assign cell_ctl[g].shift     = step && (CNT_W'(g) < top);
        assign cell_ctl[g].load_head = step && keep_sel && (CNT_W'(g) == top);
        assign cell_ctl[g].load_new  = write && (CNT_W'(g) == count_reg);

        pidq_cell #(
            .ID_WIDTH   (ID_WIDTH),
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl[g]),
            .right_id    (cell_id[(g + 1 < DEPTH) ? g + 1 : g]),
            .right_stamp (cell_stamp[(g + 1 < DEPTH) ? g + 1 : g]),
            .head_id     (cell_id[0]),
            .head_stamp  (cell_stamp[0]),
            .new_id      (id_reg),
            .new_stamp   (now_reg),
            .id          (cell_id[g]),
            .stamp       (cell_stamp[g])
        );
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign result_id = result_id_reg;
    assign last      = last_reg;

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(DEPTH - 1), "queue count beyond DEPTH-1")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready,
        state_reg != S_IDLE && !in_ready, "accepted item did not start work")
    `ASSERT_IMPLIES(a_walk_bound, clk, rst_n, state_reg == S_SRCH,
        CW'(rem_reg) + CW'(kept_reg) <= CW'(count_reg), "search walk exceeds queue")
    `ASSERT_IMPLIES(a_last_status, clk, rst_n, out_valid,
        (status == ST_DROP) == !last, "drop verdict and last flag disagree")

endmodule

[verif/tb_pending_id_queue_with_timeout_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pending_id_queue_with_timeout_core
// Self-checking bench for the pending id queue. A shadow copy of the queue
// predicts the added, found, not-found and drop verdicts for every accepted
// item. Each delivered result is compared against the oldest prediction.
// A short directed section comes first, then randomized phases under
// several timeout and capacity settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_pending_id_queue_with_timeout_core;
    import pidq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int ID_WIDTH    = 32;
    localparam int TIME_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [TIME_WIDTH-1:0] stamp;
    } pend_entry_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_WIDTH-1:0] id;
        logic                last;
    } verdict_t;

    class pending_queue_scoreboard;
        pend_entry_t            shadow_entries[$];
        verdict_t               expected_verdicts[$];
        logic [CFG_DATA_W-1:0]  timeout_r;
        logic [CAP_W-1:0]       capacity_r;
        int                     errors;

        function new();
            timeout_r  = TIMEOUT_RST;
            capacity_r = CAPACITY_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TIMEOUT)
                timeout_r = data;
            else if (idx == REG_CAPACITY)
                capacity_r = data[CAP_W-1:0];
        endfunction

        // predict the verdicts of one accepted item and update the shadow queue
        function void note_item(logic k, logic [ID_WIDTH-1:0] id, logic [TIME_WIDTH-1:0] t);
            int unsigned           cap_eff;
            int unsigned           ndrop;
            bit                    hit;
            logic [TIME_WIDTH-1:0] age;
            pend_entry_t           kept[$];
            if (k == KIND_ADD)
            begin
                cap_eff = capacity_r;
                if (cap_eff < 2)
                    cap_eff = 2;
                if (cap_eff > DEPTH)
                    cap_eff = DEPTH;
                // silent eviction of the oldest entries until at most cap_eff - 2 remain
                while (shadow_entries.size() >= cap_eff - 1 && shadow_entries.size() > 0)
                    void'(shadow_entries.pop_front());
                if (shadow_entries.size() < DEPTH)
                    shadow_entries.push_back('{id, t});
                expected_verdicts.push_back('{ST_ADDED, id, 1'b1});
            end
            else
            begin
                hit   = 1'b0;
                ndrop = 0;
                foreach (shadow_entries[r])
                begin
                    age = t - shadow_entries[r].stamp;
                    if (!hit && shadow_entries[r].id == id)
                        hit = 1'b1;
                    else if (!hit && age > timeout_r)
                    begin
                        if (ndrop < DEPTH - 1)
                        begin
                            expected_verdicts.push_back('{ST_DROP, shadow_entries[r].id, 1'b0});
                            ndrop++;
                        end
                    end
                    else
                        kept.push_back(shadow_entries[r]);
                end
                shadow_entries = kept;
                expected_verdicts.push_back('{hit ? ST_FOUND : ST_NOTFOUND, id, 1'b1});
            end
        endfunction

        function void check_result(logic [1:0] st, logic [ID_WIDTH-1:0] id, logic lst);
            verdict_t v;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d id %h last %0b", $time, st, id, lst);
                errors++;
                return;
            end
            v = expected_verdicts.pop_front();
            if (st !== v.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d", $time, v.status, st);
                errors++;
            end
            if (id !== v.id)
            begin
                $display("%0t: result_id mismatch: expected %h actual %h", $time, v.id, id);
                errors++;
            end
            if (lst !== v.last)
            begin
                $display("%0t: last mismatch: expected %0b actual %0b", $time, v.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  kind      = KIND_ADD;
    logic [ID_WIDTH-1:0]   pkt_id    = '0;
    logic [TIME_WIDTH-1:0] now       = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [ID_WIDTH-1:0]   result_id;
    logic                  last;

    pending_queue_scoreboard sb;
    bit                      idle_en = 1'b1;
    int unsigned             cycle_count = 0;
    logic [TIME_WIDTH-1:0]   clock_now = '0;
    logic [ID_WIDTH-1:0]     id_pool[16];
    int unsigned             pool_wr = 0;

    pending_id_queue_with_timeout_core #(
        .DEPTH      (DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .pkt_id    (pkt_id),
        .now       (now),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .result_id (result_id),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // transfer monitor: all three channels sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_item(kind, pkt_id, now);
            if (out_valid && out_ready)
                sb.check_result(status, result_id, last);
        end
    end

    // result sink with random stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // drive one item and return at the edge where it transfers
    task automatic send_item(input logic k, input logic [ID_WIDTH-1:0] id,
                             input logic [TIME_WIDTH-1:0] t);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        pkt_id    <= id;
        now       <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == KIND_ADD)
        begin
            id_pool[pool_wr % 16] = id;
            pool_wr++;
        end
    endtask

    // wait for the block to go idle, then write both registers back to back
    task automatic write_config(input logic [CFG_DATA_W-1:0] tmo, input logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_CAPACITY;
        cfg_data  <= {{(CFG_DATA_W-CAP_W){1'b0}}, cap};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input logic [CFG_DATA_W-1:0] tmo, input logic [CAP_W-1:0] cap,
                              input int n_items);
        logic [TIME_WIDTH-1:0] adv_max;
        logic [TIME_WIDTH-1:0] t;
        logic [ID_WIDTH-1:0]   pid;
        logic                  k;
        int                    sel;
        write_config(tmo, cap);
        adv_max = (tmo > 32'd1000) ? 32'h3fff_ffff : tmo / 3 + 2;
        // sometimes start just below the wrap point of the time counter
        if ($urandom_range(0, 3) == 0)
            clock_now = 32'hffff_ffff - $urandom_range(0, 200);
        for (int i = 0; i < n_items; i++)
        begin
            k   = ($urandom_range(0, 99) < 55) ? KIND_ADD : KIND_SEARCH;
            sel = $urandom_range(0, 99);
            if (k == KIND_ADD)
            begin
                if (sel < 30)
                    pid = $urandom_range(0, 7);
                else if (sel < 50)
                    pid = id_pool[$urandom_range(0, 15)];
                else
                    pid = $urandom;
            end
            else
            begin
                if (sel < 55)
                    pid = id_pool[$urandom_range(0, 15)];
                else if (sel < 70)
                    pid = $urandom_range(0, 7);
                else
                    pid = $urandom;
            end
            clock_now = clock_now + $urandom_range(0, adv_max);
            // occasional out-of-order time stamp
            t = ($urandom_range(0, 99) < 6) ? $urandom : clock_now;
            send_item(k, pid, t);
        end
    endtask

    initial
    begin
        sb = new();
        foreach (id_pool[i])
            id_pool[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(32'd10, 5'd16);
        send_item(KIND_ADD, 32'h0000_0000, 32'd0);
        send_item(KIND_ADD, 32'hffff_ffff, 32'd1);
        send_item(KIND_ADD, 32'd5, 32'd2);
        send_item(KIND_ADD, 32'd5, 32'd3);
        // first match wins, the later duplicate stays queued
        send_item(KIND_SEARCH, 32'd5, 32'd5);
        send_item(KIND_SEARCH, 32'd77, 32'd12);
        send_item(KIND_SEARCH, 32'd5, 32'd14);
        // search on an empty queue
        send_item(KIND_SEARCH, 32'd5, 32'd14);
        send_item(KIND_ADD, 32'd9, 32'hffff_fffe);
        send_item(KIND_ADD, 32'd10, 32'hffff_ffff);
        // ages across the time wrap, and an age equal to the timeout
        send_item(KIND_SEARCH, 32'd10, 32'd3);
        send_item(KIND_SEARCH, 32'd9, 32'd8);

        // zero timeout, small capacity: eviction on add, drop on search
        write_config(32'd0, 5'd3);
        send_item(KIND_ADD, 32'd1, 32'd100);
        send_item(KIND_ADD, 32'd2, 32'd100);
        send_item(KIND_ADD, 32'd3, 32'd101);
        send_item(KIND_SEARCH, 32'd1, 32'd101);
        send_item(KIND_SEARCH, 32'd3, 32'd101);

        // capacity lowered below the fill level
        write_config(32'hffff_ffff, 5'd16);
        send_item(KIND_ADD, 32'd11, 32'd0);
        send_item(KIND_ADD, 32'd12, 32'd5);
        send_item(KIND_ADD, 32'd13, 32'd10);
        send_item(KIND_ADD, 32'd14, 32'd20);
        write_config(32'hffff_ffff, 5'd2);
        send_item(KIND_ADD, 32'd15, 32'd30);
        send_item(KIND_SEARCH, 32'd11, 32'hffff_ffff);
        send_item(KIND_SEARCH, 32'd15, 32'd0);

        run_random(32'd10, 5'd16, 40);
        run_random(32'd0, 5'd16, 30);
        run_random(32'hffff_ffff, 5'd2, 25);
        run_random(32'd25, 5'd31, 40);
        run_random(32'd5, 5'd1, 25);
        run_random(32'd60, 5'd0, 25);
        run_random(32'd20, 5'd5, 35);
        run_random(32'($urandom_range(1, 300)), 5'($urandom_range(2, 17)), 30);
        idle_en = 1'b0;
        run_random(32'd15, 5'd8, 30);

        in_valid <= 1'b0;
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
